@@ src/pdf_eof_overlay_detector_core_assert.svh @@
// Assertion macros shared by the detector modules.
// They expect clk and rst_n to be in scope.
`ifndef PDF_EOF_OVERLAY_DETECTOR_CORE_ASSERT_SVH
`define PDF_EOF_OVERLAY_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define PDFEOF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdfeof same-cycle check failed");

// Next-cycle implication.
`define PDFEOF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdfeof next-cycle check failed");

`endif

@@ src/pdfeof_pkg.sv @@
package pdfeof_pkg;

  localparam int SIZE_BITS_DEF = 32;
  localparam int OUT_W         = 32;
  localparam int WIN_W         = 17;
  localparam int THR_W         = 16;
  localparam int CFG_IDX_W     = 1;

  localparam logic [WIN_W-1:0] WINDOW_RST    = WIN_W'(65536);
  localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(16);
  localparam int               MIN_LEN       = 6;
  localparam int               MARKER_TAIL   = 4;
  localparam int               MAGIC_LEN     = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVL_LIMIT   = 1'b1;

  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_NUL  = 8'h00;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_word_t;

  typedef struct packed {
    logic             detected;
    logic             marker_found;
    logic [OUT_W-1:0] logical_size;
    logic [OUT_W-1:0] overlay_bytes;
  } out_word_t;

  // Per-file flags captured with the final byte.
  typedef struct packed {
    logic valid;
    logic header_ok;
    logic marker_seen;
  } snap_flags_t;

  // Expected header byte at positions 0 to 4.
  function automatic logic [7:0] magic_at(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = CH_PCT;
      3'd1:    r = CH_P;
      3'd2:    r = CH_D;
      3'd3:    r = CH_F;
      3'd4:    r = CH_DASH;
      default: r = CH_NUL;
    endcase
    return r;
  endfunction

  function automatic logic is_pad(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF) || (c == CH_SP) || (c == CH_TAB) || (c == CH_NUL);
  endfunction

endpackage

@@ src/pdf_eof_overlay_detector_core.sv @@
// Channel  | Ports                          | Word
// input    | in_valid, in_stall, in_word    | in_word_t: data_byte, end_of_file
// result   | out_valid, out_stall, out_word | out_word_t: detected, marker_found,
//          |                                |   logical_size, overlay_bytes
// config   | cfg_we, cfg_index, cfg_wdata   | 0 window_size, 1 overlay limit
//
// The byte scanner takes one byte every cycle while in_stall is low, updating all per-file
// state with it. A file's summary is registered with its final byte and then in out_word.
// Reset is synchronous on rst_n; the scanner also clears itself after each final byte.
// in_stall rises only when a finished file summary waits behind a stalled result word.
module pdf_eof_overlay_detector_core
  import pdfeof_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIN_W-1:0]     cfg_wdata
);

  logic [WIN_W-1:0]     window_r, window_nxt;
  logic [THR_W-1:0]     thr_r, thr_nxt;

  snap_flags_t          snap_flags;
  logic [SIZE_BITS-1:0] snap_fsize, snap_mstart, snap_pend;
  logic                 snap_ready;

  always_comb begin
    window_nxt = window_r;
    thr_nxt    = thr_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_SIZE: window_nxt = cfg_wdata;
        CFG_OVL_LIMIT:   thr_nxt    = cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RST;
      thr_r    <= THRESHOLD_RST;
    end else begin
      window_r <= window_nxt;
      thr_r    <= thr_nxt;
    end
  end

  pdfeof_scan #(
    .SIZE_BITS(SIZE_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .snap_ready (snap_ready),
    .snap_flags (snap_flags),
    .snap_fsize (snap_fsize),
    .snap_mstart(snap_mstart),
    .snap_pend  (snap_pend)
  );

  pdfeof_report #(
    .SIZE_BITS(SIZE_BITS)
  ) u_report (
    .clk              (clk),
    .rst_n            (rst_n),
    .window_size      (window_r),
    .ovl_limit        (thr_r),
    .snap_flags       (snap_flags),
    .snap_fsize       (snap_fsize),
    .snap_mstart      (snap_mstart),
    .snap_pend        (snap_pend),
    .snap_ready       (snap_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_word         (out_word)
  );

endmodule

@@ src/pdfeof_scan.sv @@
`include "pdf_eof_overlay_detector_core_assert.svh"

module pdfeof_scan
  import pdfeof_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  input  logic                 snap_ready,
  output snap_flags_t          snap_flags,
  output logic [SIZE_BITS-1:0] snap_fsize,
  output logic [SIZE_BITS-1:0] snap_mstart,
  output logic [SIZE_BITS-1:0] snap_pend
);

  localparam logic [SIZE_BITS-1:0] POS_MAX = '1;

  logic [SIZE_BITS-1:0] pos_r, pos_nxt;
  logic                 hdr_r, hdr_nxt;
  logic [7:0]           recent_r [MARKER_TAIL];
  logic                 seen_r, seen_nxt;
  logic [SIZE_BITS-1:0] mstart_r, mstart_nxt;
  logic [SIZE_BITS-1:0] pend_r, pend_nxt;
  logic                 pad_open_r, pad_open_nxt;

  logic                 snap_v_r, snap_v_nxt;
  logic                 snap_hdr_r, snap_seen_r;
  logic [SIZE_BITS-1:0] snap_fsize_r, snap_mstart_r, snap_pend_r;

  logic                 accept;
  logic [7:0]           b;
  logic                 pos_lt5;
  logic                 eof_hit;
  logic [SIZE_BITS-1:0] pos_inc;

  assign in_stall = snap_v_r && !snap_ready;
  assign accept   = in_valid && !in_stall;
  assign b        = in_word.data_byte;
  assign pos_lt5  = pos_r < SIZE_BITS'(MAGIC_LEN);
  assign pos_inc  = (pos_r == POS_MAX) ? pos_r : pos_r + SIZE_BITS'(1);
  assign eof_hit  = (pos_r >= SIZE_BITS'(MARKER_TAIL)) && (b == CH_F) &&
                    (recent_r[0] == CH_PCT) && (recent_r[1] == CH_PCT) &&
                    (recent_r[2] == CH_E) && (recent_r[3] == CH_O);

  always_comb begin
    hdr_nxt      = hdr_r && !(pos_lt5 && (b != magic_at(pos_r[2:0])));
    seen_nxt     = seen_r;
    mstart_nxt   = mstart_r;
    pend_nxt     = pend_r;
    pad_open_nxt = pad_open_r;
    pos_nxt      = pos_inc;
    if (eof_hit) begin
      seen_nxt     = 1'b1;
      mstart_nxt   = pos_r - SIZE_BITS'(MARKER_TAIL);
      pend_nxt     = pos_inc;
      pad_open_nxt = 1'b1;
    end else if (pad_open_r) begin
      if (is_pad(b)) begin
        pend_nxt = pos_inc;
      end else begin
        pad_open_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    snap_v_nxt = snap_v_r;
    if (accept && in_word.end_of_file) begin
      snap_v_nxt = 1'b1;
    end else if (snap_ready) begin
      snap_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      hdr_r      <= 1'b1;
      seen_r     <= 1'b0;
      mstart_r   <= '0;
      pend_r     <= '0;
      pad_open_r <= 1'b0;
      for (int i = 0; i < MARKER_TAIL; i++) begin
        recent_r[i] <= 8'h00;
      end
    end else if (accept) begin
      if (in_word.end_of_file) begin
        // clear for the next file
        pos_r      <= '0;
        hdr_r      <= 1'b1;
        seen_r     <= 1'b0;
        mstart_r   <= '0;
        pend_r     <= '0;
        pad_open_r <= 1'b0;
        for (int i = 0; i < MARKER_TAIL; i++) begin
          recent_r[i] <= 8'h00;
        end
      end else begin
        pos_r      <= pos_nxt;
        hdr_r      <= hdr_nxt;
        seen_r     <= seen_nxt;
        mstart_r   <= mstart_nxt;
        pend_r     <= pend_nxt;
        pad_open_r <= pad_open_nxt;
        for (int i = 0; i < MARKER_TAIL - 1; i++) begin
          recent_r[i] <= recent_r[i+1];
        end
        recent_r[MARKER_TAIL-1] <= b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
    end else begin
      snap_v_r <= snap_v_nxt;
    end
  end

  // capture the file summary with the final byte's updates folded in
  always_ff @(posedge clk) begin
    if (accept && in_word.end_of_file) begin
      snap_hdr_r    <= hdr_nxt;
      snap_seen_r   <= seen_nxt;
      snap_fsize_r  <= pos_inc;
      snap_mstart_r <= mstart_nxt;
      snap_pend_r   <= pend_nxt;
    end
  end

  assign snap_flags.valid       = snap_v_r;
  assign snap_flags.header_ok   = snap_hdr_r;
  assign snap_flags.marker_seen = snap_seen_r;
  assign snap_fsize             = snap_fsize_r;
  assign snap_mstart            = snap_mstart_r;
  assign snap_pend              = snap_pend_r;

  `PDFEOF_ASSERT_NXT(a_pos_clear, accept && in_word.end_of_file, pos_r == '0)
  `PDFEOF_ASSERT_IMP(a_pad_needs_marker, pad_open_r, seen_r)
  `PDFEOF_ASSERT_IMP(a_hdr_rise_at_eof, $rose(hdr_r), $past(accept && in_word.end_of_file))

endmodule

@@ src/pdfeof_report.sv @@
`include "pdf_eof_overlay_detector_core_assert.svh"

module pdfeof_report
  import pdfeof_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [WIN_W-1:0]     window_size,
  input  logic [THR_W-1:0]     ovl_limit,
  input  snap_flags_t          snap_flags,
  input  logic [SIZE_BITS-1:0] snap_fsize,
  input  logic [SIZE_BITS-1:0] snap_mstart,
  input  logic [SIZE_BITS-1:0] snap_pend,
  output logic                 snap_ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word
);

  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_word_r, out_word_nxt;

  logic [SIZE_BITS-1:0] win, thr, chk, span, tail, logical, overlay;
  logic                 found, use_pad;
  logic [SIZE_BITS+OUT_W-1:0] logical_ext, overlay_ext;

  assign snap_ready = !out_valid_r || !out_stall;

  always_comb begin
    win     = SIZE_BITS'(window_size);
    thr     = SIZE_BITS'(ovl_limit);
    chk     = (win < snap_fsize) ? win : snap_fsize;
    span    = snap_fsize - snap_mstart;
    tail    = snap_fsize - snap_pend;
    found   = snap_flags.header_ok && snap_flags.marker_seen &&
              (snap_fsize >= SIZE_BITS'(MIN_LEN)) && (chk >= SIZE_BITS'(MIN_LEN)) &&
              (snap_mstart <= snap_fsize) && (span <= chk);
    use_pad = found && (snap_pend <= snap_fsize);
    logical = use_pad ? snap_pend : snap_fsize;
    overlay = use_pad ? tail : '0;
    // keep the low output bits, zero-filling when sizes are narrower
    logical_ext = {{OUT_W{1'b0}}, logical};
    overlay_ext = {{OUT_W{1'b0}}, overlay};
    out_word_nxt.detected      = found && (overlay > thr);
    out_word_nxt.marker_found  = found;
    out_word_nxt.logical_size  = logical_ext[OUT_W-1:0];
    out_word_nxt.overlay_bytes = overlay_ext[OUT_W-1:0];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (snap_ready) begin
      out_valid_nxt = snap_flags.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_flags.valid) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `PDFEOF_ASSERT_IMP(a_detect_needs_marker, out_valid_r && out_word_r.detected,
                     out_word_r.marker_found)
  `PDFEOF_ASSERT_NXT(a_snap_moves_out, snap_flags.valid && snap_ready, out_valid_r)
  `PDFEOF_ASSERT_IMP(a_no_marker_no_overlay, out_valid_r && !out_word_r.marker_found,
                     out_word_r.overlay_bytes == '0)

endmodule

@@ tb/tb_pdf_eof_overlay_detector_core.sv @@
`timescale 1ns / 1ps
module tb_pdf_eof_overlay_detector_core;
  import pdfeof_pkg::*;

  localparam longint unsigned POS_LIMIT = 64'hFFFF_FFFF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_BYTES = 600;
  localparam logic [7:0] PDF_SIG [MAGIC_LEN] = '{CH_PCT, CH_P, CH_D, CH_F, CH_DASH};
  localparam logic [7:0] PAD_CHARS [5] = '{CH_CR, CH_LF, CH_SP, CH_TAB, CH_NUL};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW_SIZE;
  logic [WIN_W-1:0]     cfg_wdata = '0;

  // Scanner state mirrored for prediction
  logic [WIN_W-1:0] win_len;
  logic [THR_W-1:0] ovl_limit;
  longint unsigned  pos_cnt, mk_start, pad_end;
  bit               hdr_ok, mk_seen, pad_open;
  logic [7:0]       tail [MARKER_TAIL];

  out_word_t  pending_summaries[$];
  logic [7:0] file_buf[$];
  int         errors = 0;
  int         cycle_cnt = 0;
  int         sent_bytes = 0;
  int         sent_files = 0;
  bit         calm = 1'b0;

  pdf_eof_overlay_detector_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic bit is_blank(input logic [7:0] b);
    return b == PAD_CHARS[0] || b == PAD_CHARS[1] || b == PAD_CHARS[2] ||
           b == PAD_CHARS[3] || b == PAD_CHARS[4];
  endfunction

  function automatic void clear_scan();
    pos_cnt = 0;
    hdr_ok = 1'b1;
    foreach (tail[i]) tail[i] = 8'h00;
    mk_seen = 1'b0;
    mk_start = 0;
    pad_end = 0;
    pad_open = 1'b0;
  endfunction

  // Advance the scanner by one byte; returns 1 with the file summary on the last byte.
  function automatic bit scan_byte(input logic [7:0] b, input logic last,
                                   output out_word_t summary);
    longint unsigned p, fsize, span, logical, extra;
    bit found;
    p = pos_cnt;
    summary = '0;
    if (p < MAGIC_LEN && b != PDF_SIG[p]) hdr_ok = 1'b0;
    if (p >= MARKER_TAIL && b == CH_F && tail[0] == CH_PCT && tail[1] == CH_PCT &&
        tail[2] == CH_E && tail[3] == CH_O) begin
      mk_seen = 1'b1;
      mk_start = p - MARKER_TAIL;
      pad_end = (p < POS_LIMIT) ? p + 1 : POS_LIMIT;
      pad_open = 1'b1;
    end else if (pad_open) begin
      if (is_blank(b)) pad_end = (p < POS_LIMIT) ? p + 1 : POS_LIMIT;
      else pad_open = 1'b0;
    end
    tail[0] = tail[1];
    tail[1] = tail[2];
    tail[2] = tail[3];
    tail[3] = b;
    if (pos_cnt < POS_LIMIT) pos_cnt++;
    if (!last) return 1'b0;

    fsize = (p < POS_LIMIT) ? p + 1 : POS_LIMIT;
    span = (win_len < fsize) ? win_len : fsize;
    found = hdr_ok && p >= MAGIC_LEN - 1 && fsize >= MIN_LEN && span >= MIN_LEN &&
            mk_seen && mk_start <= fsize && (fsize - mk_start) <= span;
    logical = (found && pad_end <= fsize) ? pad_end : fsize;
    extra = fsize - logical;
    summary.detected = found && extra > ovl_limit;
    summary.marker_found = found;
    summary.logical_size = logical[OUT_W-1:0];
    summary.overlay_bytes = extra[OUT_W-1:0];
    clear_scan();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  always @(posedge clk) begin : check_results
    out_word_t want;
    out_stall <= !calm && ($urandom_range(99) < 30);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_summaries.size() == 0) begin
        report_mismatch("result word with no file pending", out_word.logical_size, 0);
      end else begin
        want = pending_summaries.pop_front();
        if (out_word.detected !== want.detected)
          report_mismatch("detected", out_word.detected, want.detected);
        if (out_word.marker_found !== want.marker_found)
          report_mismatch("marker_found", out_word.marker_found, want.marker_found);
        if (out_word.logical_size !== want.logical_size)
          report_mismatch("logical_size", out_word.logical_size, want.logical_size);
        if (out_word.overlay_bytes !== want.overlay_bytes)
          report_mismatch("overlay_bytes", out_word.overlay_bytes, want.overlay_bytes);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    out_word_t summary;
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{data_byte: b, end_of_file: last};
    // hold the word until it is taken
    do @(posedge clk); while (in_stall);
    if (scan_byte(b, last, summary)) pending_summaries.push_back(summary);
    sent_bytes++;
  endtask

  task automatic send_file();
    foreach (file_buf[i]) send_byte(file_buf[i], i == file_buf.size() - 1);
    file_buf.delete();
    sent_files++;
  endtask

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) file_buf.push_back(s[i]);
  endfunction

  function automatic void put_pads(input int n);
    repeat (n) file_buf.push_back(PAD_CHARS[$urandom_range(4)]);
  endfunction

  function automatic void put_junk(input int n);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom_range(255)); while (is_blank(b));
      file_buf.push_back(b);
    end
  endfunction

  function automatic void put_any(input int n);
    repeat (n) file_buf.push_back(8'($urandom_range(255)));
  endfunction

  // Drop valid and wait until the block has nothing left in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_WINDOW_SIZE) win_len = val;
    else ovl_limit = val[THR_W-1:0];
  endtask

  task automatic set_regs(input logic [WIN_W-1:0] win, input logic [WIN_W-1:0] thr);
    settle();
    write_reg(CFG_WINDOW_SIZE, win);
    write_reg(CFG_OVL_LIMIT, thr);
    cfg_we <= 1'b0;
  endtask

  task automatic test_header_and_length();
    put_text("%PDF-%%EOF");
    send_file();
    put_text("%");
    send_file();
    put_text("%PDF");
    send_file();
    put_text("%PDF-");
    send_file();
    put_text("%PDF-");
    file_buf.push_back(8'hFF);
    send_file();
    file_buf.push_back(8'h00);
    file_buf.push_back(8'hFF);
    send_file();
    put_text("%PDX-%%EOF");
    put_junk(20);
    send_file();
  endtask

  task automatic test_marker_padding();
    // every pad character, then overlay just over and at the default threshold
    put_text("%PDF-");
    put_junk(3);
    put_text("%%EOF");
    foreach (PAD_CHARS[i]) file_buf.push_back(PAD_CHARS[i]);
    put_junk(17);
    send_file();
    put_text("%PDF-%%EOF\n");
    put_junk(16);
    send_file();
    // a later marker replaces the earlier one
    put_text("%PDF-%%EOF\n");
    put_junk(20);
    put_text("%%EOF\n");
    put_junk(2);
    send_file();
    // padding closes at the first other byte
    put_text("%PDF-%%EOF");
    file_buf.push_back(CH_CR);
    put_text("x\n\n");
    send_file();
    put_text("%PDF-");
    put_junk(4);
    put_text("%%%EOF");
    send_file();
  endtask

  task automatic test_window();
    set_regs(17'd7, 17'd0);
    put_text("%PDF-%%EOFab");
    send_file();
    set_regs(17'd6, 17'd0);
    put_text("%PDF-%%EOFab");
    send_file();
    put_text("%PDF-%%EOF");
    send_file();
    set_regs(17'd5, 17'd0);
    put_text("%PDF-%%EOF");
    send_file();
    set_regs(17'd0, 17'd0);
    put_text("%PDF-%%EOF ");
    send_file();
  endtask

  // Largest window, first with the largest threshold, then with one the overlay exceeds.
  task automatic test_long_overlay();
    set_regs(17'h1FFFF, 17'h0FFFF);
    put_text("%PDF-%%EOF");
    put_junk(120);
    send_file();
    set_regs(17'h1FFFF, 17'd100);
    put_text("%PDF-%%EOF");
    put_junk(120);
    send_file();
  endtask

  task automatic build_random_file();
    int kind, n, markers;
    string frame;
    kind = $urandom_range(99);
    if (kind < 10) begin
      put_any($urandom_range(12, 1));
    end else if (kind < 20) begin
      frame = "%PDF-%%EOF";
      n = $urandom_range(7, 1);
      for (int i = 0; i < n; i++) file_buf.push_back(frame[i]);
      if ($urandom_range(1)) file_buf[$urandom_range(n - 1)] = 8'($urandom_range(255));
    end else begin
      put_text("%PDF-");
      if (kind < 28) file_buf[$urandom_range(MAGIC_LEN - 1)] = 8'($urandom_range(255));
      put_junk($urandom_range(20));
      markers = (kind < 33) ? 0 : $urandom_range(2, 1);
      for (int m = 0; m < markers; m++) begin
        put_text("%%EOF");
        put_pads($urandom_range(5));
        put_any($urandom_range((m == markers - 1) ? 40 : 8));
      end
    end
  endtask

  task automatic test_random_files();
    logic [WIN_W-1:0] win_set [6];
    int phase_start, phase_files;
    win_set = '{WINDOW_RST, 17'd20, 17'd6, 17'h1FFFF, 17'd40, 17'd3};
    foreach (win_set[ph]) begin
      set_regs(win_set[ph], {1'($urandom_range(1)), 16'($urandom_range(30))});
      calm = (ph == 1);
      phase_start = sent_bytes;
      phase_files = 0;
      while (sent_bytes - phase_start < RANDOM_BYTES / 6 || phase_files < 4) begin
        build_random_file();
        send_file();
        phase_files++;
      end
      calm = 1'b0;
    end
    set_regs(WINDOW_RST, 17'h0FFFF);
    repeat (6) begin
      build_random_file();
      send_file();
    end
  endtask

  initial begin
    win_len = WINDOW_RST;
    ovl_limit = THRESHOLD_RST;
    clear_scan();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_header_and_length();
    test_marker_padding();
    test_window();
    test_long_overlay();
    test_random_files();

    settle();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/pdfeof_pkg.sv
src/pdfeof_scan.sv
src/pdfeof_report.sv
src/pdf_eof_overlay_detector_core.sv
tb/tb_pdf_eof_overlay_detector_core.sv
